// ----- sv/frm_pkg.sv -----
// shared widths, command and status codes for the remove-matching fifo
package frm_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;
  localparam int CMD_W         = 2;
  localparam int ST_W          = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- sv/frm_ram.sv -----
// entry store: one write port, one read port with registered read data
module frm_ram #(
  parameter  int DEPTH  = frm_pkg::DEPTH_DEFAULT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [ADDR_W-1:0]                  wr_addr,
  input  logic signed [frm_pkg::DATA_W-1:0]  wr_data,
  input  logic                               rd_en,
  input  logic [ADDR_W-1:0]                  rd_addr,
  output logic signed [frm_pkg::DATA_W-1:0]  rd_data
);

  logic signed [frm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/fifo_remove_matching.sv -----
// top level: bounded ring fifo with append, pop and in-place remove-matching
//
//   channel   ports                                           handshake
//   -------   ---------------------------------------------   -------------------------
//   command   command, value                                  start high and busy low
//   result    head_value, entries_left, removed_count, status strobe high for one cycle
//
// append, a failed pop, a remove on an empty store and the unused code answer
// straight away: the result word shows on the cycle after the start edge
// a good pop passes through S_POP for one registered read of the entry store
// remove-matching runs a sweep in S_SWEEP: the sweep reads one entry and writes
// back at most one survivor per cycle through the single read and write port
// rst is synchronous and clears the fsm, head, count and the result strobe; the
// store itself is not cleared, only slots that hold entries are ever read
// results cannot be held off by the receiver, busy alone paces the commands
module fifo_remove_matching #(
  parameter  int QUEUE_DEPTH = frm_pkg::DEPTH_DEFAULT,
  localparam int IDX_W       = $clog2(QUEUE_DEPTH),
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [frm_pkg::CMD_W-1:0]          command,
  input  logic signed [frm_pkg::DATA_W-1:0]  value,
  output logic                               strobe,
  output logic signed [frm_pkg::DATA_W-1:0]  head_value,
  output logic [CNT_W-1:0]                   entries_left,
  output logic [CNT_W-1:0]                   removed_count,
  output logic [frm_pkg::ST_W-1:0]           status
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POP   = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  // ring slot at a given offset from a base slot, offset below the depth
  function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[IDX_W-1:0];
  endfunction

  state_t                             state, state_next;
  logic [IDX_W-1:0]                   head, head_next;
  logic [CNT_W-1:0]                   count, count_next;
  logic [CNT_W-1:0]                   rd_idx, rd_idx_next;  // next entry to read in a sweep
  logic [CNT_W-1:0]                   keep, keep_next;      // survivors written so far
  logic                               rd_pending, rd_pending_next;
  logic signed [frm_pkg::DATA_W-1:0]  key, key_next;

  logic                               strobe_next;
  logic signed [frm_pkg::DATA_W-1:0]  head_value_next;
  logic [CNT_W-1:0]                   entries_left_next;
  logic [CNT_W-1:0]                   removed_next;
  logic [frm_pkg::ST_W-1:0]           status_next;

  // store ports
  logic                               wr_en, rd_en;
  logic [IDX_W-1:0]                   wr_addr, rd_addr;
  logic signed [frm_pkg::DATA_W-1:0]  wr_data, rd_data;

  frm_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    head_next         = head;
    count_next        = count;
    rd_idx_next       = rd_idx;
    keep_next         = keep;
    rd_pending_next   = 1'b0;
    key_next          = key;
    strobe_next       = 1'b0;
    head_value_next   = '0;
    entries_left_next = count;
    removed_next      = '0;
    status_next       = frm_pkg::ST_OK;
    wr_en             = 1'b0;
    wr_addr           = slot_after(head, keep);
    wr_data           = rd_data;
    rd_en             = 1'b0;
    rd_addr           = slot_after(head, rd_idx);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            frm_pkg::CMD_APPEND: begin
              strobe_next = 1'b1;
              if (count == DEPTH_C) begin
                status_next = frm_pkg::ST_FULL;
              end else begin
                // write straight at the tail slot
                wr_en             = 1'b1;
                wr_addr           = slot_after(head, count);
                wr_data           = value;
                count_next        = count + CNT_W'(1);
                entries_left_next = count + CNT_W'(1);
              end
            end
            frm_pkg::CMD_REMOVE: begin
              if (count == '0) begin
                strobe_next = 1'b1;
              end else begin
                // first read goes out now, the sweep handles the rest
                rd_en           = 1'b1;
                rd_addr         = head;
                rd_idx_next     = CNT_W'(1);
                keep_next       = '0;
                rd_pending_next = 1'b1;
                key_next        = value;
                state_next      = S_SWEEP;
              end
            end
            frm_pkg::CMD_POP: begin
              if (count == '0) begin
                strobe_next = 1'b1;
                status_next = frm_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                state_next = S_POP;
              end
            end
            default: begin
              // unused code: report the count, change nothing
              strobe_next = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        strobe_next       = 1'b1;
        head_value_next   = rd_data;
        head_next         = slot_after(head, CNT_W'(1));
        count_next        = count - CNT_W'(1);
        entries_left_next = count - CNT_W'(1);
        removed_next      = CNT_W'(1);
        state_next        = S_IDLE;
      end

      S_SWEEP: begin
        // read ahead of the write pointer: keep never passes the slot being
        // read, so a write-back only lands on a slot already read
        if (rd_idx != count) begin
          rd_en           = 1'b1;
          rd_idx_next     = rd_idx + CNT_W'(1);
          rd_pending_next = 1'b1;
        end
        if (rd_pending && (rd_data != key)) begin
          wr_en     = 1'b1;
          keep_next = keep + CNT_W'(1);
        end
        if (!rd_pending) begin
          strobe_next       = 1'b1;
          count_next        = keep;
          entries_left_next = keep;
          removed_next      = count - keep;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      rd_idx     <= '0;
      keep       <= '0;
      rd_pending <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      rd_idx     <= rd_idx_next;
      keep       <= keep_next;
      rd_pending <= rd_pending_next;
      strobe     <= strobe_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    key           <= key_next;
    head_value    <= head_value_next;
    entries_left  <= entries_left_next;
    removed_count <= removed_next;
    status        <= status_next;
  end

  // occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");

  // an accepted word either answers next cycle or keeps the block busy
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (strobe || busy))
    else $error("accepted word neither answered nor in progress");

  // the pop read always completes into a result word
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (strobe && !busy))
    else $error("pop did not produce a result");

  // compaction write pointer never passes the read pointer, which never passes the count
  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> ((keep <= rd_idx) && (rd_idx <= count)))
    else $error("sweep pointers out of order");

  // no store write while a pop read is outstanding
  a_pop_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> !wr_en)
    else $error("store written during pop");

endmodule
